// ----- design/ec_affine_point_add_core_macros.svh -----
// Assertion macros for the affine point adder
`ifndef EC_AFFINE_POINT_ADD_CORE_MACROS_SVH
`define EC_AFFINE_POINT_ADD_CORE_MACROS_SVH
// implication checked every clock outside reset
`define EC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define EC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- design/ecpa_pkg.sv -----
// Package: widths, constants and control types for the point adder
`default_nettype none
package ecpa_pkg;
  localparam int MOD_BITS = 16;
  localparam logic [15:0] CURVE_A_RESET = 16'd0;
  localparam logic [15:0] MODULUS_RESET = 16'd65521;
  localparam logic [0:0] REG_CURVE_A = 1'b0;
  localparam logic [0:0] REG_MODULUS = 1'b1;

  // shared unit operations
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_MOD = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;
endpackage
`default_nettype wire

// ----- design/ecpa_if.sv -----
// Channel interfaces for the point adder
`default_nettype none
interface ecpa_in_if #(parameter int W = ecpa_pkg::MOD_BITS);
  logic         valid;
  logic         ready;
  logic [W-1:0] p1_x;
  logic [W-1:0] p1_y;
  logic         p1_infinity;
  logic [W-1:0] p2_x;
  logic [W-1:0] p2_y;
  logic         p2_infinity;
  modport source (output valid, p1_x, p1_y, p1_infinity, p2_x, p2_y, p2_infinity,
                  input ready);
  modport sink (input valid, p1_x, p1_y, p1_infinity, p2_x, p2_y, p2_infinity,
                output ready);
endinterface

interface ecpa_out_if #(parameter int W = ecpa_pkg::MOD_BITS);
  logic         valid;
  logic         ready;
  logic [W-1:0] r_x;
  logic [W-1:0] r_y;
  logic         r_infinity;
  modport source (output valid, r_x, r_y, r_infinity, input ready);
  modport sink (input valid, r_x, r_y, r_infinity, output ready);
endinterface

interface ecpa_cfg_if #(parameter int W = ecpa_pkg::MOD_BITS);
  logic         valid;
  logic         ready;
  logic         index;
  logic [W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/ecpa_unit.sv -----
// Shared bit-serial unit: modular multiply, divide (quotient and remainder)
`default_nettype none
module ecpa_unit #(
  parameter int W = ecpa_pkg::MOD_BITS
) (
  input  wire                  clk,
  input  wire                  rst,
  input  ecpa_pkg::unit_ctl_t  ctl,
  input  wire  [W-1:0]         opa,
  input  wire  [W-1:0]         opb,
  input  wire  [W-1:0]         m,
  output ecpa_pkg::unit_sts_t  sts,
  output logic [W-1:0]         quo,
  output logic [W-1:0]         res
);
  localparam int CW = $clog2(W + 1);

  logic [W:0]    acc;
  logic [W-1:0]  shf;
  logic [W-1:0]  divs;
  logic [W-1:0]  q;
  logic [1:0]    op;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [W+1:0]  dbl;
  logic [W+1:0]  sum;
  logic [W:0]    rem_sh;
  logic [W:0]    acc_next;
  logic          qbit;

  // one step: multiply is double-and-add from the top bit of shf,
  // divide is restoring shift-subtract with dividend bits from shf
  always_comb begin
    dbl = {1'b0, acc} << 1;
    if (dbl >= {2'b00, m}) dbl = dbl - {2'b00, m};
    sum = dbl + (shf[W-1] ? {2'b00, opa} : '0);
    if (sum >= {2'b00, m}) sum = sum - {2'b00, m};
    rem_sh = {acc[W-1:0], shf[W-1]};
    qbit = rem_sh >= {1'b0, divs};
    acc_next = qbit ? rem_sh - {1'b0, divs} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        op   <= ctl.op;
        acc  <= '0;
        shf  <= (ctl.op == ecpa_pkg::OP_MUL) ? opb : opa;
        divs <= (ctl.op == ecpa_pkg::OP_MUL) ? m : opb;
        q    <= '0;
      end else if (busy) begin
        if (op == ecpa_pkg::OP_MUL) begin
          acc <= sum[W:0];
        end else begin
          acc <= acc_next;
          q   <= {q[W-2:0], qbit};
        end
        shf <= shf << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quo = q;
  assign res = acc[W-1:0];
endmodule
`default_nettype wire

// ----- design/ecpa_seq.sv -----
// Sequencer: steps the point addition through the shared unit
`default_nettype none
module ecpa_seq #(
  parameter int W = ecpa_pkg::MOD_BITS
) (
  input  wire                  clk,
  input  wire                  rst,
  ecpa_in_if.sink              in_ch,
  ecpa_out_if.source           out_ch,
  input  wire  [W-1:0]         curve_a,
  input  wire  [W-1:0]         modulus,
  output ecpa_pkg::unit_ctl_t  uctl,
  output logic [W-1:0]         uopa,
  output logic [W-1:0]         uopb,
  input  ecpa_pkg::unit_sts_t  usts,
  input  wire  [W-1:0]         uquo,
  input  wire  [W-1:0]         ures,
  output logic                 idle
);
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RED   = 5'd1;   // reduce operands modulo m
  localparam logic [4:0] S_CASE  = 5'd2;
  localparam logic [4:0] S_SQ    = 5'd3;
  localparam logic [4:0] S_SLOPE = 5'd4;
  localparam logic [4:0] S_EUC   = 5'd5;   // quotient/remainder step
  localparam logic [4:0] S_EUCM  = 5'd6;   // q*t1 mod m
  localparam logic [4:0] S_EUCC  = 5'd7;
  localparam logic [4:0] S_SMUL  = 5'd8;
  localparam logic [4:0] S_SS    = 5'd9;
  localparam logic [4:0] S_Y3    = 5'd10;
  localparam logic [4:0] S_OUT   = 5'd11;
  localparam logic [4:0] S_WAIT  = 5'd12;

  logic [4:0]   state;
  logic [2:0]   ridx;
  logic         issued;
  logic [W-1:0] x1, y1, x2, y2, a, num, den, r0, r1, t0, t1, q, s, x3;
  logic         i1, i2;
  logic [W-1:0] ox, oy;
  logic         oinf, ovalid;

  function automatic logic [W-1:0] addm(input logic [W-1:0] u, v, mm);
    logic [W:0] t;
    t = {1'b0, u} + {1'b0, v};
    if (t >= {1'b0, mm}) t = t - {1'b0, mm};
    return t[W-1:0];
  endfunction

  function automatic logic [W-1:0] subm(input logic [W-1:0] u, v, mm);
    return (u >= v) ? u - v : u + (mm - v);
  endfunction

  assign idle = (state == S_IDLE) && !ovalid;
  assign in_ch.ready = (state == S_IDLE) && !ovalid;
  assign out_ch.valid = ovalid;
  assign out_ch.r_x = ox;
  assign out_ch.r_y = oy;
  assign out_ch.r_infinity = oinf;

  // unit command for the current step
  always_comb begin
    uctl.start = !issued && !usts.busy && !usts.done &&
                 (state == S_RED || state == S_SQ || state == S_EUC ||
                  state == S_EUCM || state == S_SMUL || state == S_SS ||
                  state == S_Y3);
    uctl.op = ecpa_pkg::OP_MUL;
    uopa = '0;
    uopb = '0;
    unique case (state)
      S_RED: begin
        uctl.op = ecpa_pkg::OP_MOD;
        uopb = modulus;
        unique case (ridx)
          3'd0: uopa = x1;
          3'd1: uopa = y1;
          3'd2: uopa = x2;
          3'd3: uopa = y2;
          default: uopa = a;
        endcase
      end
      S_SQ: begin uopa = x1; uopb = x1; end
      S_EUC: begin uctl.op = ecpa_pkg::OP_DIV; uopa = r0; uopb = r1; end
      S_EUCM: begin uopa = q; uopb = t1; end
      S_SMUL: begin uopa = num; uopb = t0; end
      S_SS: begin uopa = s; uopb = s; end
      S_Y3: begin uopa = s; uopb = subm(x1, x3, modulus); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
      ovalid <= 1'b0;
      ridx   <= '0;
    end else begin
      if (uctl.start) issued <= 1'b1;
      if (ovalid && out_ch.ready) ovalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            x1 <= in_ch.p1_x; y1 <= in_ch.p1_y; i1 <= in_ch.p1_infinity;
            x2 <= in_ch.p2_x; y2 <= in_ch.p2_y; i2 <= in_ch.p2_infinity;
            a <= curve_a;
            ridx <= '0;
            if (modulus < W'(2) || (in_ch.p1_infinity && in_ch.p2_infinity)) begin
              ox <= '0; oy <= '0; oinf <= 1'b1; ovalid <= 1'b1;
            end else begin
              state <= S_RED;
            end
          end
        end
        S_RED: if (usts.done) begin
          issued <= 1'b0;
          unique case (ridx)
            3'd0: x1 <= ures;
            3'd1: y1 <= ures;
            3'd2: x2 <= ures;
            3'd3: y2 <= ures;
            default: a <= ures;
          endcase
          ridx <= ridx + 1'b1;
          if (ridx == 3'd4) state <= S_CASE;
        end
        S_CASE: begin
          if (i1) begin
            ox <= x2; oy <= y2; oinf <= 1'b0; state <= S_OUT;
          end else if (i2) begin
            ox <= x1; oy <= y1; oinf <= 1'b0; state <= S_OUT;
          end else if (x1 == x2 && y1 == y2) begin
            den <= addm(y1, y1, modulus);
            state <= S_SQ;
          end else begin
            num <= subm(y2, y1, modulus);
            den <= subm(x2, x1, modulus);
            state <= S_SLOPE;
          end
        end
        S_SQ: if (usts.done) begin
          issued <= 1'b0;
          num <= addm(addm(addm(ures, ures, modulus), ures, modulus), a, modulus);
          state <= S_SLOPE;
        end
        S_SLOPE: begin
          if (den == '0) begin
            ox <= '0; oy <= '0; oinf <= 1'b1; state <= S_OUT;
          end else if (num == '0) begin
            s <= '0; state <= S_SS;
          end else begin
            r0 <= modulus; r1 <= den; t0 <= '0; t1 <= W'(1);
            state <= S_EUC;
          end
        end
        S_EUC: if (usts.done) begin
          issued <= 1'b0;
          q <= uquo;
          r0 <= r1;
          r1 <= ures;
          state <= S_EUCM;
        end
        S_EUCM: if (usts.done) begin
          issued <= 1'b0;
          t0 <= t1;
          t1 <= subm(t0, ures, modulus);
          state <= S_EUCC;
        end
        S_EUCC: begin
          if (r1 != '0) state <= S_EUC;
          else if (r0 != W'(1)) begin
            ox <= '0; oy <= '0; oinf <= 1'b1; state <= S_OUT;
          end else state <= S_SMUL;
        end
        S_SMUL: if (usts.done) begin
          issued <= 1'b0; s <= ures; state <= S_SS;
        end
        S_SS: if (usts.done) begin
          issued <= 1'b0;
          x3 <= subm(subm(ures, x1, modulus), x2, modulus);
          state <= S_Y3;
        end
        S_Y3: if (usts.done) begin
          issued <= 1'b0;
          ox <= x3; oy <= subm(ures, y1, modulus); oinf <= 1'b0;
          state <= S_OUT;
        end
        S_OUT: begin
          ovalid <= 1'b1; state <= S_WAIT;
        end
        S_WAIT: if (!ovalid) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/ec_affine_point_add_core.sv -----
// Top level of the affine elliptic-curve point adder
//
//  channel   dir  payload                                   role
//  in_ch     in   p1_x p1_y p1_infinity p2_x p2_y p2_inf.   point pair request
//  out_ch    out  r_x r_y r_infinity                        sum result
//  cfg_ch    in   index data                                curve_a / modulus writes
//
// Each request first reduces its five operands modulo the modulus on the unit,
// then runs the multiplies and the Euclid rounds (a divide and a multiply each).
// The time for a sum is set by the Euclid round count on the single
// bit-serial unit. rst is synchronous, active high.
// in_ch.ready is low from acceptance until the result is taken and the state is S_IDLE;
// out_ch stalls hold the result in its register. Config writes are accepted
// only while the block is idle.
`default_nettype none
`include "ec_affine_point_add_core_macros.svh"
module ec_affine_point_add_core #(
  parameter int MOD_BITS = ecpa_pkg::MOD_BITS
) (
  input wire          clk,
  input wire          rst,
  ecpa_in_if.sink     in_ch,
  ecpa_out_if.source  out_ch,
  ecpa_cfg_if.sink    cfg_ch
);
  logic [MOD_BITS-1:0] curve_a, modulus;
  ecpa_pkg::unit_ctl_t uctl;
  ecpa_pkg::unit_sts_t usts;
  logic [MOD_BITS-1:0] uopa, uopb, uquo, ures;
  logic                idle;

  // writes only land while no request is in flight
  assign cfg_ch.ready = idle;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_a <= MOD_BITS'(ecpa_pkg::CURVE_A_RESET);
      modulus <= MOD_BITS'(ecpa_pkg::MODULUS_RESET);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == ecpa_pkg::REG_CURVE_A) curve_a <= cfg_ch.data;
      else modulus <= cfg_ch.data;
    end
  end

  ecpa_unit #(.W(MOD_BITS)) u_unit (
    .clk(clk), .rst(rst), .ctl(uctl), .opa(uopa), .opb(uopb), .m(modulus),
    .sts(usts), .quo(uquo), .res(ures)
  );

  ecpa_seq #(.W(MOD_BITS)) u_seq (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .curve_a(curve_a), .modulus(modulus),
    .uctl(uctl), .uopa(uopa), .uopb(uopb), .usts(usts), .uquo(uquo), .ures(ures),
    .idle(idle)
  );

  `EC_ASSERT_IMPL(a_no_start_busy, clk, rst, uctl.start, !usts.busy, "unit restarted while busy")
  `EC_ASSERT_IMPL(a_ready_idle, clk, rst, in_ch.ready, !out_ch.valid && !usts.busy, "ready while working")
  `EC_ASSERT_NEXT(a_inf_zero, clk, rst, out_ch.valid && out_ch.r_infinity, out_ch.r_x == '0 || !out_ch.valid, "infinity with coordinates")
endmodule
`default_nettype wire
